// File: rtl/nsq_pkg.sv
// ----------------------------------------------------------------------------
// nsq_pkg
// Shared types, constants and helpers for the note scale quantizer.
// ----------------------------------------------------------------------------
package nsq_pkg;

    // Held-note mask size
    localparam int NOTE_COUNT_DEF = 128;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int NOTE_W   = 7;
    localparam int RES_W    = 9;
    localparam int MATRIX_W = 48;
    localparam int ROOT_W   = 4;
    localparam int PC_W     = 4;
    localparam int DIST_W   = 8;
    localparam int CFG_IDX_W = 2;

    // Port widths
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 2;

    // Arithmetic constants
    localparam logic [PC_W-1:0]    PC_MAX        = 4'd11;
    localparam logic [RES_W-1:0]   OCTAVE        = 9'd12;
    localparam logic [DIST_W-1:0]  MUTE_DISTANCE = 8'd6;

    // Register reset values
    localparam logic [ROOT_W-1:0]   ROOT_RESET   = 4'd0;
    localparam logic [MATRIX_W-1:0] MATRIX_RESET = 48'hBA9876543210;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROOT_NOTE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_MATRIX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HELD_ENABLE = 2'd2;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_NOTE_ON  = 2'd0,
        CMD_NOTE_OFF = 2'd1,
        CMD_ALL_OFF  = 2'd2,
        CMD_QUERY    = 2'd3
    } cmd_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HDONE,
        ST_PREP,
        ST_DIV,
        ST_MAP,
        ST_OUT,
        ST_CLEAR
    } state_t;

    // Shared subtract unit result
    typedef struct packed {
        logic signed [RES_W-1:0] diff;
        logic [DIST_W-1:0]       mag;
        logic                    neg;
    } alu_res_t;

    // Matrix lookup, clamped to the top pitch class
    function automatic logic [PC_W-1:0] matrix_entry(input logic [MATRIX_W-1:0] m,
                                                     input logic [PC_W-1:0] pc);
        logic [PC_W-1:0] v;
        begin
            case (pc)
                4'd0:    v = m[3:0];
                4'd1:    v = m[7:4];
                4'd2:    v = m[11:8];
                4'd3:    v = m[15:12];
                4'd4:    v = m[19:16];
                4'd5:    v = m[23:20];
                4'd6:    v = m[27:24];
                4'd7:    v = m[31:28];
                4'd8:    v = m[35:32];
                4'd9:    v = m[39:36];
                4'd10:   v = m[43:40];
                4'd11:   v = m[47:44];
                default: v = PC_MAX;
            endcase
            matrix_entry = (v > PC_MAX) ? PC_MAX : v;
        end
    endfunction

endpackage

// File: rtl/note_scale_quantizer_unit.sv
// ----------------------------------------------------------------------------
// note_scale_quantizer_unit
// Pitch-scale quantizer with a held-note mask and nearest-held-note snapping.
// ----------------------------------------------------------------------------
// Note on and note off words update the mask as they are taken and give no
// result. The held mask is a small memory: after reset, and after each
// all-notes-off word, a clearing pass zeroes it one note a cycle with
// s_tready low. A query word is worked on by a small sequencer around one
// shared subtract unit. In held mode the unit walks the held mask one note a
// cycle to find the nearest held note. Otherwise, or when nothing is held,
// the pitch class is found by repeated subtraction of 12 and then mapped
// through the matrix. The finished result waits in the sequencer until the
// output register is free, and then in the output register, so a new word
// is taken while it is still undelivered.
module note_scale_quantizer_unit
    import nsq_pkg::*;
#(
    parameter int NOTE_COUNT = NOTE_COUNT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [MATRIX_W-1:0]   cfg_wdata,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [6:0] note, [7] zero
    input  logic [S_TUSER_W-1:0]  s_tuser,   // [1:0] cmd
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [8:0] mapped_note, [15:9] zero
    output logic [M_TUSER_W-1:0]  m_tuser    // [0] muted, [1] from_held
);

    localparam int IDX_W = $clog2(NOTE_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NOTE_COUNT - 1);

    // configuration registers
    logic [ROOT_W-1:0]   root_reg;
    logic [MATRIX_W-1:0] matrix_reg;
    logic                held_en_reg;

    // sequencer registers
    state_t                  state_reg, state_next;
    logic [NOTE_W-1:0]       note_reg, note_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    found_reg, found_next;
    logic [IDX_W-1:0]        best_reg, best_next;
    logic [DIST_W-1:0]       dist_reg, dist_next;
    logic signed [RES_W-1:0] val_reg, val_next;
    logic signed [RES_W-1:0] res_note_reg, res_note_next;
    logic                    res_muted_reg, res_muted_next;
    logic                    res_held_reg, res_held_next;

    // output register
    logic                    m_valid_reg, m_valid_next;
    logic [RES_W-1:0]        m_note_reg, m_note_next;
    logic [M_TUSER_W-1:0]    m_user_reg, m_user_next;

    // datapath
    logic                    s_accept;
    cmd_t                    s_cmd;
    logic [NOTE_W-1:0]       s_note;
    logic                    note_in_range;
    logic                    clearing;
    logic                    held_wr_en;
    logic [IDX_W-1:0]        held_wr_idx;
    logic                    held_wr_val;
    logic                    held_bit;
    logic signed [RES_W-1:0] alu_a, alu_b;
    alu_res_t                alu_res;
    logic [ROOT_W-1:0]       root_eff;
    logic [PC_W-1:0]         pc;

    assign s_cmd         = cmd_t'(s_tuser[CMD_W-1:0]);
    assign s_note        = s_tdata[NOTE_W-1:0];
    assign s_tready      = (state_reg == ST_IDLE);
    assign s_accept      = s_tvalid && s_tready;
    assign note_in_range = ({1'b0, s_note} < (NOTE_W+1)'(NOTE_COUNT));
    assign clearing      = (state_reg == ST_CLEAR);
    // clearing pass or a single note on/off
    assign held_wr_en    = clearing || (s_accept && note_in_range &&
                           ((s_cmd == CMD_NOTE_ON) || (s_cmd == CMD_NOTE_OFF)));
    assign held_wr_idx   = clearing ? idx_reg : s_note[IDX_W-1:0];
    assign held_wr_val   = !clearing && (s_cmd == CMD_NOTE_ON);
    assign root_eff      = (root_reg > PC_MAX) ? PC_MAX : root_reg;
    assign pc            = val_reg[PC_W-1:0];

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg    <= ROOT_RESET;
            matrix_reg  <= MATRIX_RESET;
            held_en_reg <= 1'b0;
        end else if (cfg_wen) begin
            case (cfg_index)
                REG_ROOT_NOTE:    root_reg    <= cfg_wdata[ROOT_W-1:0];
                REG_PITCH_MATRIX: matrix_reg  <= cfg_wdata;
                REG_HELD_ENABLE:  held_en_reg <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    // held-note mask, addressed with the next index so the bit is ready in the scan
    nsq_held #(
        .NOTE_COUNT (NOTE_COUNT)
    ) u_held (
        .aclk    (aclk),
        .wr_en   (held_wr_en),
        .wr_idx  (held_wr_idx),
        .wr_val  (held_wr_val),
        .rd_idx  (idx_next),
        .rd_bit  (held_bit)
    );

    // shared subtract unit
    nsq_alu u_alu (
        .op_a (alu_a),
        .op_b (alu_b),
        .res  (alu_res)
    );

    // operand select per step
    always_comb begin
        case (state_reg)
            ST_SCAN: begin
                alu_a = RES_W'(note_reg);
                alu_b = RES_W'(idx_reg);
            end
            ST_PREP: begin
                alu_a = RES_W'(note_reg) + OCTAVE;
                alu_b = RES_W'(root_eff);
            end
            ST_DIV: begin
                alu_a = val_reg;
                alu_b = OCTAVE;
            end
            ST_MAP: begin
                alu_a = RES_W'(note_reg) + RES_W'(matrix_entry(matrix_reg, pc));
                alu_b = RES_W'(pc);
            end
            default: begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    // state and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
        note_reg      <= note_next;
        found_reg     <= found_next;
        best_reg      <= best_next;
        dist_reg      <= dist_next;
        val_reg       <= val_next;
        res_note_reg  <= res_note_next;
        res_muted_reg <= res_muted_next;
        res_held_reg  <= res_held_next;
        m_note_reg    <= m_note_next;
        m_user_reg    <= m_user_next;
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        note_next      = note_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        dist_next      = dist_reg;
        val_next       = val_reg;
        res_note_next  = res_note_reg;
        res_muted_next = res_muted_reg;
        res_held_next  = res_held_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_note_next    = m_note_reg;
        m_user_next    = m_user_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept && (s_cmd == CMD_QUERY)) begin
                    note_next  = s_note;
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = held_en_reg ? ST_SCAN : ST_PREP;
                end else if (s_accept && (s_cmd == CMD_ALL_OFF)) begin
                    idx_next   = '0;
                    state_next = ST_CLEAR;
                end
            end
            // zero the mask one note a cycle
            ST_CLEAR: begin
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            // one held bit per cycle, strict compare keeps the lower note
            ST_SCAN: begin
                if (held_bit && (!found_reg || (alu_res.mag < dist_reg))) begin
                    found_next = 1'b1;
                    best_next  = idx_reg;
                    dist_next  = alu_res.mag;
                end
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_HDONE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_HDONE: begin
                if (found_reg) begin
                    res_note_next  = RES_W'(best_reg);
                    res_muted_next = (dist_reg > MUTE_DISTANCE);
                    res_held_next  = 1'b1;
                    state_next     = ST_OUT;
                end else begin
                    state_next = ST_PREP;
                end
            end
            // note - root + 12, always positive
            ST_PREP: begin
                val_next   = alu_res.diff;
                state_next = ST_DIV;
            end
            // strip octaves until the pitch class is left
            ST_DIV: begin
                if (!alu_res.neg) begin
                    val_next = alu_res.diff;
                end else begin
                    state_next = ST_MAP;
                end
            end
            // note - pc + matrix[pc]
            ST_MAP: begin
                res_note_next  = alu_res.diff;
                res_muted_next = 1'b0;
                res_held_next  = 1'b0;
                state_next     = ST_OUT;
            end
            // hand over once the output register is free
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_note_next  = res_note_reg;
                    m_user_next  = {res_held_reg, res_muted_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-RES_W){1'b0}}, m_note_reg};
    assign m_tuser  = m_user_reg;

endmodule

// File: rtl/nsq_alu.sv
// ----------------------------------------------------------------------------
// nsq_alu
// Shared subtract unit: difference, magnitude and sign of a - b.
// ----------------------------------------------------------------------------
module nsq_alu
    import nsq_pkg::*;
(
    input  logic signed [RES_W-1:0] op_a,
    input  logic signed [RES_W-1:0] op_b,
    output alu_res_t                res
);

    logic signed [RES_W-1:0] diff;

    // one subtract, then absolute value of the narrow result
    assign diff     = op_a - op_b;
    assign res.diff = diff;
    assign res.neg  = diff[RES_W-1];
    assign res.mag  = diff[RES_W-1] ? DIST_W'(-diff) : DIST_W'(diff);

endmodule

// File: rtl/nsq_held.sv
// ----------------------------------------------------------------------------
// nsq_held
// Held-note mask: one-bit memory with a write port and a registered read port.
// ----------------------------------------------------------------------------
module nsq_held
    import nsq_pkg::*;
#(
    parameter int NOTE_COUNT = NOTE_COUNT_DEF,
    localparam int IDX_W = $clog2(NOTE_COUNT)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic             wr_val,
    input  logic [IDX_W-1:0] rd_idx,
    output logic             rd_bit
);

    logic held_mem [NOTE_COUNT];
    logic rd_bit_reg;

    // note on/off and clearing pass, one entry per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            held_mem[wr_idx] <= wr_val;
        end
    end

    // registered read, data appears the cycle after the address
    always_ff @(posedge aclk) begin
        rd_bit_reg <= held_mem[rd_idx];
    end

    assign rd_bit = rd_bit_reg;

endmodule

// File: tb/nsq_result_checker.sv
// ----------------------------------------------------------------------------
// nsq_result_checker
// Watches the configuration port and both streams of the note scale
// quantizer, keeps its own copy of the held-note mask and registers, works
// out the mapped note for every query word and compares each result word
// against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module nsq_result_checker
    import nsq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [MATRIX_W-1:0]   cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [6:0] note, [7] zero
    input  logic [S_TUSER_W-1:0]  s_tuser,   // [1:0] cmd
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,   // [8:0] mapped_note, [15:9] zero
    input  logic [M_TUSER_W-1:0]  m_tuser,   // [0] muted, [1] from_held
    output int                    pending_words,
    output int                    fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEMITONES  = 12;
    localparam int TOP_CLASS  = 11;
    localparam int MUTE_SPAN  = 6;
    localparam int MAX_REPORT = 10;

    typedef struct packed {
        logic [RES_W-1:0] mapped;
        logic             muted;
        logic             from_held;
    } quant_result_t;

    // Shadow copy of the block's registers and held mask
    logic [ROOT_W-1:0]         root_sel;
    logic [MATRIX_W-1:0]       scale_map;
    logic                      snap_on;
    logic [NOTE_COUNT_DEF-1:0] held_mask;
    quant_result_t             expected_q[$];

    // Nearest held note when snapping applies, scale mapping otherwise
    function automatic quant_result_t predict_query(input logic [NOTE_W-1:0] qnote);
        quant_result_t r;
        int  k, note_gap, best_dist, root_c, rel, octave, pclass, entry;
        bit  found;
        r = '0;
        found = 1'b0;
        best_dist = 0;
        if (snap_on) begin
            // ascending scan with strict compare: the lower note wins a tie
            for (k = 0; k < NOTE_COUNT_DEF; k++) begin
                if (held_mask[k]) begin
                    note_gap = int'(qnote) - k;
                    if (note_gap < 0) note_gap = -note_gap;
                    if (!found || note_gap < best_dist) begin
                        r.mapped = RES_W'(k);
                        best_dist = note_gap;
                        found = 1'b1;
                    end
                end
            end
        end
        if (found) begin
            r.muted = (best_dist > MUTE_SPAN);
            r.from_held = 1'b1;
        end else begin
            root_c = (int'(root_sel) > TOP_CLASS) ? TOP_CLASS : int'(root_sel);
            rel = int'(qnote) - root_c;
            // floored octave, rel never below -11
            octave = (rel + 2 * SEMITONES) / SEMITONES - 2;
            pclass = rel - octave * SEMITONES;
            entry = int'(scale_map[pclass*PC_W +: PC_W]);
            if (entry > TOP_CLASS) entry = TOP_CLASS;
            r.mapped = RES_W'(root_c + octave * SEMITONES + entry);
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        quant_result_t got;
        quant_result_t want;
        logic [NOTE_W-1:0] word_note;
        if (!aresetn) begin
            root_sel = ROOT_RESET;
            scale_map = MATRIX_RESET;
            snap_on = 1'b0;
            held_mask = '0;
            expected_q.delete();
            pending_words = 0;
            fail_count = 0;
        end else begin
            // register writes
            if (cfg_wen) begin
                case (cfg_index)
                    REG_ROOT_NOTE:    root_sel = cfg_wdata[ROOT_W-1:0];
                    REG_PITCH_MATRIX: scale_map = cfg_wdata;
                    REG_HELD_ENABLE:  snap_on = cfg_wdata[0];
                    default: ;
                endcase
            end

            // result side first: a result never belongs to a word taken this edge
            if (m_tvalid && m_tready) begin
                got.mapped = m_tdata[RES_W-1:0];
                got.muted = m_tuser[0];
                got.from_held = m_tuser[1];
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORT)
                        $display("%0t: result word with none expected: note %0d muted %0b held %0b",
                                 $time, $signed(got.mapped), got.muted, got.from_held);
                end else begin
                    want = expected_q.pop_front();
                    if (got.mapped !== want.mapped || got.muted !== want.muted ||
                        got.from_held !== want.from_held) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORT) begin
                            $write("%0t: mismatch: expected note %0d muted %0b held %0b,",
                                   $time, $signed(want.mapped), want.muted, want.from_held);
                            $display(" got note %0d muted %0b held %0b",
                                     $signed(got.mapped), got.muted, got.from_held);
                        end
                    end
                end
            end

            // input side: update mask or queue a prediction
            if (s_tvalid && s_tready) begin
                word_note = s_tdata[NOTE_W-1:0];
                case (cmd_t'(s_tuser))
                    CMD_NOTE_ON:  if (int'(word_note) < NOTE_COUNT_DEF) held_mask[word_note] = 1'b1;
                    CMD_NOTE_OFF: if (int'(word_note) < NOTE_COUNT_DEF) held_mask[word_note] = 1'b0;
                    CMD_ALL_OFF:  held_mask = '0;
                    CMD_QUERY:    expected_q.insert(expected_q.size(), predict_query(word_note));
                    default: ;
                endcase
            end
            pending_words = expected_q.size();
        end
    end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the note scale quantizer unit.
// A directed pass covers note extremes, root and matrix clamping, negative
// results, ties, muting and the fallback to scale mode; then random phases
// with changing register settings, random idling on both streams and one
// long hold-off on the result side. Checking lives in nsq_result_checker.
// ----------------------------------------------------------------------------
module tb;
    import nsq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES   = 160;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 250;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [MATRIX_W-1:0]   cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    int                    pending_words;
    int                    fail_count;
    int                    stall_cycles = 0;
    int                    send_idle_pct = 0;
    int                    take_idle_pct = 0;
    bit                    calm = 1'b0;
    bit                    pressure_req = 1'b0;
    bit                    pressure_done = 1'b0;
    logic [NOTE_W-1:0]     recent_note = '0;

    note_scale_quantizer_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    nsq_result_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .pending_words (pending_words),
        .fail_count    (fail_count)
    );

    // 8 ns clock
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Watchdog: cycles in a row with no word moving on either stream
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off, steady in the last phase
    initial begin : result_sink
        int gap;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (pressure_req && !pressure_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge aclk);
                pressure_done = 1'b1;
            end else if (!calm && $urandom_range(1, 100) <= take_idle_pct) begin
                gap = $urandom_range(1, 19);
                m_tready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one word, called and returning at a falling edge
    task automatic send_word(input cmd_t cmd, input logic [NOTE_W-1:0] note);
        int gap;
        if (!calm && $urandom_range(1, 100) <= send_idle_pct) begin
            gap = $urandom_range(1, 19);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= S_TDATA_W'(note);
        s_tuser <= cmd;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Drop valid, let outstanding results drain and the sequencer finish
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_words != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MATRIX_W-1:0] val);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
    endtask

    task automatic apply_config(input logic [ROOT_W-1:0] root, input logic [MATRIX_W-1:0] map,
                                input logic snap);
        settle();
        write_reg(REG_ROOT_NOTE, MATRIX_W'(root));
        write_reg(REG_PITCH_MATRIX, map);
        write_reg(REG_HELD_ENABLE, MATRIX_W'(snap));
        cfg_wen <= 1'b0;
    endtask

    // Mostly note events and queries; all-off now and then keeps the mask sparse
    task automatic random_word();
        int roll;
        logic [NOTE_W-1:0] n;
        roll = $urandom_range(0, 99);
        n = NOTE_W'($urandom_range(0, 127));
        if (roll < 28) begin
            if ($urandom_range(0, 3) == 0)
                n = NOTE_W'((int'(recent_note) + $urandom_range(0, 16) + 120) % 128);
            recent_note = n;
            send_word(CMD_NOTE_ON, n);
        end else if (roll < 42) begin
            send_word(CMD_NOTE_OFF, $urandom_range(0, 1) ? recent_note : n);
        end else if (roll < 46) begin
            send_word(CMD_ALL_OFF, n);
        end else begin
            send_word(CMD_QUERY, n);
        end
    endtask

    initial begin : stimulus
        int phase;
        logic [63:0] map_rand;
        logic [ROOT_W-1:0] root_rand;
        logic snap_rand;
        aresetn = 1'b0;
        cfg_wen = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // identity scale, note extremes and alternating bit patterns
        apply_config(4'd0, MATRIX_RESET, 1'b0);
        send_word(CMD_QUERY, 7'd0);
        send_word(CMD_QUERY, 7'd127);
        send_word(CMD_QUERY, 7'd85);
        send_word(CMD_QUERY, 7'd42);
        send_word(CMD_QUERY, 7'd11);

        // root above eleven, matrix entries above eleven, negative result
        apply_config(4'd15, 48'hFFFF_FFFF_0000, 1'b0);
        send_word(CMD_QUERY, 7'd0);
        send_word(CMD_QUERY, 7'd10);
        send_word(CMD_QUERY, 7'd127);

        // held mode: empty-mask fallback, tie, muting, mask clearing
        apply_config(4'd5, 48'h0123_4567_89AB, 1'b1);
        send_word(CMD_QUERY, 7'd60);
        send_word(CMD_NOTE_ON, 7'd60);
        send_word(CMD_NOTE_ON, 7'd70);
        send_word(CMD_QUERY, 7'd65);
        send_word(CMD_QUERY, 7'd67);
        send_word(CMD_QUERY, 7'd127);
        send_word(CMD_NOTE_OFF, 7'd60);
        send_word(CMD_QUERY, 7'd0);
        send_word(CMD_ALL_OFF, 7'd0);
        send_word(CMD_QUERY, 7'd10);
        send_word(CMD_NOTE_ON, 7'd0);
        send_word(CMD_NOTE_ON, 7'd127);
        send_word(CMD_QUERY, 7'd63);
        send_word(CMD_QUERY, 7'd64);

        // random phases, each under its own register setting
        for (phase = 0; phase < PHASES; phase++) begin
            map_rand = {$urandom(), $urandom()};
            root_rand = ROOT_W'($urandom_range(0, 15));
            snap_rand = 1'($urandom_range(0, 1));
            case (phase)
                0:       apply_config(4'd0, '0, 1'b0);
                1:       apply_config(4'd15, {MATRIX_W{1'b1}}, 1'b1);
                4:       apply_config(4'd11, map_rand[MATRIX_W-1:0], 1'b1);
                default: apply_config(root_rand, map_rand[MATRIX_W-1:0], snap_rand);
            endcase
            calm = (phase == PHASES - 1);
            send_idle_pct = (phase == 3) ? 0 : $urandom_range(5, 40);
            take_idle_pct = (phase == 3) ? 0 : $urandom_range(5, 40);
            if (phase == 2) pressure_req = 1'b1;
            repeat (WORDS_PER_PHASE) random_word();
        end

        settle();
        if (fail_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
